>>> sv/pp2rgb_pkg.sv
`default_nettype none
package pp2rgb_pkg;

	localparam logic [2:0] FMT_YUYV  = 3'd0;
	localparam logic [2:0] FMT_YVYU  = 3'd1;
	localparam logic [2:0] FMT_UYVY  = 3'd2;
	localparam logic [2:0] FMT_RGB24 = 3'd3;
	localparam logic [2:0] FMT_BGR24 = 3'd4;

	localparam logic [7:0] ALPHA_OPAQUE = 8'hff;

	localparam logic signed [9:0] Y_OFFSET  = 10'sd16;
	localparam logic signed [8:0] UV_OFFSET = 9'sd128;

	localparam logic signed [10:0] K_Y  = 11'sd298;
	localparam logic signed [10:0] K_RV = 11'sd409;
	localparam logic signed [10:0] K_GU = 11'sd100;
	localparam logic signed [10:0] K_GV = 11'sd208;
	localparam logic signed [10:0] K_BU = 11'sd516;
	localparam logic signed [19:0] ROUND_HALF = 20'sd128;

	typedef struct packed {
		logic       copy;
		logic       last;
		logic [7:0] y;
		logic [7:0] u;
		logic [7:0] v;
	} pix_t;

	function automatic logic [7:0] clamp_channel(input logic signed [19:0] acc);
		logic signed [11:0] sh;
		logic [7:0]         res;
		begin
			sh = acc[19:8];
			if (sh[11]) begin
				res = 8'd0;
			end else if (|sh[10:8]) begin
				res = 8'hff;
			end else begin
				res = sh[7:0];
			end
			return res;
		end
	endfunction

endpackage
`default_nettype wire

>>> sv/pp2rgb_conv_pipe.sv
`default_nettype none
module pp2rgb_conv_pipe
	import pp2rgb_pkg::*;
(
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        in_valid,
	output logic             in_ready,
	input  wire pix_t        in_pix,
	output logic             out_valid,
	input  wire logic        out_ready,
	output logic [31:0]      out_data,
	output logic             out_last
);

	logic en_s1, en_s2, en_s3;
	logic v_s1, v_s2, v_s3;

	// stage 1: offsets and constant products
	logic                copy_s1, last_s1;
	logic [23:0]         byt_s1;
	logic signed [18:0]  pc_s1;
	logic signed [17:0]  pbu_s1;
	logic signed [15:0]  pgu_s1;
	logic signed [16:0]  pgv_s1;
	logic signed [16:0]  prv_s1;

	// stage 2: channel sums
	logic                copy_s2, last_s2;
	logic [23:0]         byt_s2;
	logic signed [19:0]  accb_s2, accg_s2, accr_s2;

	// stage 3: clamp and output register
	logic [31:0]         data_s3;
	logic                last_s3;
	logic                copy_s3;

	logic signed [9:0]   c_d;
	logic signed [8:0]   d_d, e_d;
	logic signed [18:0]  pc_d, pbu_d, pgu_d, pgv_d, prv_d;

	assign en_s3    = !v_s3 || out_ready;
	assign en_s2    = !v_s2 || en_s3;
	assign en_s1    = !v_s1 || en_s2;
	assign in_ready = en_s1;

	always_comb begin
		c_d   = $signed({2'b00, in_pix.y}) - Y_OFFSET;
		d_d   = $signed({1'b0, in_pix.u}) - UV_OFFSET;
		e_d   = $signed({1'b0, in_pix.v}) - UV_OFFSET;
		pc_d  = 19'(c_d) * 19'(K_Y);
		pbu_d = 19'(d_d) * 19'(K_BU);
		pgu_d = 19'(d_d) * 19'(K_GU);
		pgv_d = 19'(e_d) * 19'(K_GV);
		prv_d = 19'(e_d) * 19'(K_RV);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
		end else begin
			if (en_s1) v_s1 <= in_valid;
			if (en_s2) v_s2 <= v_s1;
			if (en_s3) v_s3 <= v_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (en_s1) begin
			copy_s1 <= in_pix.copy;
			last_s1 <= in_pix.last;
			byt_s1  <= {in_pix.v, in_pix.u, in_pix.y};
			pc_s1   <= pc_d;
			pbu_s1  <= pbu_d[17:0];
			pgu_s1  <= pgu_d[15:0];
			pgv_s1  <= pgv_d[16:0];
			prv_s1  <= prv_d[16:0];
		end
		if (en_s2) begin
			copy_s2 <= copy_s1;
			last_s2 <= last_s1;
			byt_s2  <= byt_s1;
			accb_s2 <= 20'(pc_s1) + 20'(pbu_s1) + ROUND_HALF;
			accg_s2 <= 20'(pc_s1) - 20'(pgu_s1) - 20'(pgv_s1) + ROUND_HALF;
			accr_s2 <= 20'(pc_s1) + 20'(prv_s1) + ROUND_HALF;
		end
		if (en_s3) begin
			last_s3 <= last_s2;
			copy_s3 <= copy_s2;
			if (copy_s2) begin
				data_s3 <= {ALPHA_OPAQUE, byt_s2};
			end else begin
				data_s3 <= {ALPHA_OPAQUE, clamp_channel(accr_s2),
					clamp_channel(accg_s2), clamp_channel(accb_s2)};
			end
		end
	end

	assign out_valid = v_s3;
	assign out_data  = data_s3;
	assign out_last  = last_s3;

	// a copied pixel is always the only pixel of its item
	a_copy_is_last: assert property (@(posedge clk) disable iff (!arst_n)
		v_s3 && copy_s3 |-> last_s3)
		else $error("copied pixel without tlast");

	// a held output may only move on once taken
	a_stall_no_advance: assert property (@(posedge clk) disable iff (!arst_n)
		v_s3 && !out_ready && v_s2 |=> v_s3 && v_s2)
		else $error("pipeline lost an item during stall");

	// a pixel accepted at the input makes stage 1 valid
	a_s1_load: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> v_s1)
		else $error("accepted pixel not in stage 1");

endmodule
`default_nettype wire

>>> sv/packed_pixel_to_rgb32.sv
// Packed pixel to RGB32 converter. Each s_axis transfer carries four source bytes; the
// format register picks YUYV, YVYU, UYVY (codes five to seven act as YUYV), RGB24 or BGR24.
// A 4:2:2 macropixel gives two BT.601 pixels (B, G, R, alpha 255), the second with tlast;
// the RGB modes give one copied pixel with tlast. While m_axis_tready is high one pixel
// leaves per cycle, so an RGB transfer is taken every cycle and a new YUV transfer only as
// the held one issues its second pixel; the single pixel lane of the pipeline sets this.
// An input transfer passes the input hold register and three pipeline stages on its way
// out. Write the format only while no transfer is in flight.
`default_nettype none
module packed_pixel_to_rgb32
	import pp2rgb_pkg::*;
(
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        cfg_valid,
	output logic             cfg_ready,
	input  wire logic [2:0]  cfg_data,        // pixel_format
	input  wire logic        s_axis_tvalid,
	output logic             s_axis_tready,
	input  wire logic [31:0] s_axis_tdata,    // src_byte0, src_byte1, src_byte2, src_byte3
	output logic             m_axis_tvalid,
	input  wire logic        m_axis_tready,
	output logic [31:0]      m_axis_tdata,    // out_byte0, out_byte1, out_byte2, alpha_byte
	output logic             m_axis_tlast     // last_of_item
);

	logic [2:0] fmt_q;
	logic       sp_valid_q;
	logic       sp_phase_q;
	logic       sp_copy_q;
	logic [7:0] y0_q, y1_q, u_q, v_q;

	logic [7:0] b0, b1, b2, b3;
	logic [7:0] y0_d, y1_d, u_d, v_d;
	logic       copy_d;
	logic       accept, issue, sp_last, pipe_ready;
	pix_t       pix;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fmt_q <= FMT_YUYV;
		end else if (cfg_valid && cfg_ready) begin
			fmt_q <= cfg_data;
		end
	end

	assign b0 = s_axis_tdata[7:0];
	assign b1 = s_axis_tdata[15:8];
	assign b2 = s_axis_tdata[23:16];
	assign b3 = s_axis_tdata[31:24];

	// for copies y/u/v carry the three output bytes in order
	always_comb begin
		copy_d = 1'b0;
		y0_d   = b0;
		u_d    = b1;
		y1_d   = b2;
		v_d    = b3;
		case (fmt_q)
			FMT_YVYU: begin
				y0_d = b0; v_d = b1; y1_d = b2; u_d = b3;
			end
			FMT_UYVY: begin
				u_d = b0; y0_d = b1; v_d = b2; y1_d = b3;
			end
			FMT_RGB24: begin
				copy_d = 1'b1;
				y0_d = b0; u_d = b1; v_d = b2;
			end
			FMT_BGR24: begin
				copy_d = 1'b1;
				y0_d = b2; u_d = b1; v_d = b0;
			end
			default: begin
				y0_d = b0; u_d = b1; y1_d = b2; v_d = b3;
			end
		endcase
	end

	assign sp_last       = sp_copy_q || sp_phase_q;
	assign issue         = sp_valid_q && pipe_ready;
	assign s_axis_tready = !sp_valid_q || (pipe_ready && sp_last);
	assign accept        = s_axis_tvalid && s_axis_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sp_valid_q <= 1'b0;
			sp_phase_q <= 1'b0;
		end else if (accept) begin
			sp_valid_q <= 1'b1;
			sp_phase_q <= 1'b0;
		end else if (issue) begin
			if (sp_last) begin
				sp_valid_q <= 1'b0;
				sp_phase_q <= 1'b0;
			end else begin
				sp_phase_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			sp_copy_q <= copy_d;
			y0_q      <= y0_d;
			y1_q      <= y1_d;
			u_q       <= u_d;
			v_q       <= v_d;
		end
	end

	always_comb begin
		pix.copy = sp_copy_q;
		pix.last = sp_last;
		pix.y    = sp_phase_q ? y1_q : y0_q;
		pix.u    = u_q;
		pix.v    = v_q;
	end

	pp2rgb_conv_pipe u_pipe (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (sp_valid_q),
		.in_ready  (pipe_ready),
		.in_pix    (pix),
		.out_valid (m_axis_tvalid),
		.out_ready (m_axis_tready),
		.out_data  (m_axis_tdata),
		.out_last  (m_axis_tlast)
	);

	// a new transfer only lands when the held item issues its final pixel
	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		accept && sp_valid_q |-> issue && sp_last)
		else $error("held item overwritten");

	// the second pixel phase exists only for yuv items
	a_phase_yuv: assert property (@(posedge clk) disable iff (!arst_n)
		sp_valid_q && sp_phase_q |-> !sp_copy_q)
		else $error("second pixel on a copy item");

	// first yuv pixel issued moves to the second phase
	a_phase_step: assert property (@(posedge clk) disable iff (!arst_n)
		issue && !sp_last |=> sp_valid_q && sp_phase_q)
		else $error("second yuv pixel dropped");

endmodule
`default_nettype wire
